/* design/stream_k_smallest_select_top_assert.svh */
// assertion macros for the streaming k-smallest selector
`ifndef STREAM_K_SMALLEST_SELECT_TOP_ASSERT_SVH
`define STREAM_K_SMALLEST_SELECT_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SKS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle rule");

// next-cycle implication, checked out of reset
`define SKS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle rule");

`endif

/* design/sks_pkg.sv */
// shared types and constants for the streaming k-smallest selector
package sks_pkg;

  localparam int VALUE_W      = 30;
  localparam int KEEP_W       = 5;
  localparam int MAX_KEEP_DEF = 16;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last_item;
  } sks_in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] smallest_value;
    logic               end_of_list;
  } sks_out_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } sks_cmd_t;

  typedef struct packed {
    logic one_left;
  } sks_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } sks_state_e;

endpackage

/* design/stream_k_smallest_select_top.sv */
// top level of the streaming k-smallest selector
// Usage:
//   Input: drive item_i and raise start; the transaction is taken at a rising
//   edge where start is high and busy is low. Each item is sorted into a chain
//   of compare cells at the edge that takes it, so a new item can follow every
//   cycle while busy stays low.
//   Config: cfg_we_i with cfg_wdata_i writes keep_count (reset 16, 0 acts as
//   1, values above MAX_KEEP act as MAX_KEEP); write only while not busy.
//   Output: after an item with last_item set, busy rises in the next cycle and
//   the n held values (n = min(items in the set, keep count)) appear in
//   ascending order, one per cycle on result_o with result_valid_o high;
//   end_of_list marks the final one. busy falls after the last result, and
//   the held count is cleared for the next set.
//   Readout: the first result appears in the cycle after the last item is taken;
//   all results leave through the single readout head of the cell chain.
//   The receiver cannot stall; each result is valid for exactly one cycle.
//   Reset: the held count clears, keep_count returns to 16, busy is low.
module stream_k_smallest_select_top #(
  parameter int MAX_KEEP = sks_pkg::MAX_KEEP_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  sks_pkg::sks_in_t           item_i,
  input  logic                       cfg_we_i,
  input  logic [sks_pkg::KEEP_W-1:0] cfg_wdata_i,
  output logic                       result_valid_o,
  output sks_pkg::sks_out_t          result_o
);

  sks_pkg::sks_cmd_t           cmd;
  sks_pkg::sks_stat_t          stat;
  logic [sks_pkg::VALUE_W-1:0] head;

  sks_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .last_item_i (item_i.last_item),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy_o      (busy)
  );

  sks_datapath #(
    .MAX_KEEP (MAX_KEEP)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .value_i     (item_i.value),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .head_o      (head)
  );

  assign result_valid_o          = cmd.shift;
  assign result_o.smallest_value = head;
  assign result_o.end_of_list    = stat.one_left;

`include "stream_k_smallest_select_top_assert.svh"

  `SKS_ASSERT_NOW(a_result_while_busy, result_valid_o, busy)
  `SKS_ASSERT_NEXT(a_plain_item_no_result, start && !busy && !item_i.last_item,
                   !result_valid_o)
  `SKS_ASSERT_NEXT(a_last_item_starts_list, start && !busy && item_i.last_item,
                   result_valid_o)
  `SKS_ASSERT_NEXT(a_end_releases_busy, result_valid_o && result_o.end_of_list, !busy)

endmodule

/* design/sks_ctrl.sv */
// controller: accepts transactions and sequences the sorted readout
module sks_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              last_item_i,
  input  sks_pkg::sks_stat_t stat_i,
  output sks_pkg::sks_cmd_t  cmd_o,
  output logic              busy_o
);

  sks_pkg::sks_state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o.insert = 1'b0;
    cmd_o.shift  = 1'b0;
    unique case (state_q)
      sks_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.insert = 1'b1;
          if (last_item_i) state_d = sks_pkg::ST_EMIT;
        end
      end
      sks_pkg::ST_EMIT: begin
        cmd_o.shift = 1'b1;
        if (stat_i.one_left) state_d = sks_pkg::ST_IDLE;
      end
      default: state_d = sks_pkg::ST_IDLE;
    endcase
  end

  assign busy_o = (state_q == sks_pkg::ST_EMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sks_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/sks_datapath.sv */
// datapath: sorted chain of compare cells, held count and keep register
module sks_datapath #(
  parameter int MAX_KEEP = sks_pkg::MAX_KEEP_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sks_pkg::KEEP_W-1:0]  cfg_wdata_i,
  input  logic [sks_pkg::VALUE_W-1:0] value_i,
  input  sks_pkg::sks_cmd_t           cmd_i,
  output sks_pkg::sks_stat_t          stat_o,
  output logic [sks_pkg::VALUE_W-1:0] head_o
);

  localparam int CW = $clog2(MAX_KEEP + 1);
  localparam int KW = (CW > sks_pkg::KEEP_W) ? CW : sks_pkg::KEEP_W;

  logic [sks_pkg::KEEP_W-1:0]  keep_q;
  logic [CW-1:0]               count_q, count_d;
  logic [sks_pkg::VALUE_W-1:0] cell_q [MAX_KEEP];
  logic [KW-1:0]               keep_ext;
  logic [CW-1:0]               keep_eff, count_eff;
  logic [MAX_KEEP-1:0]         gt;

  assign keep_ext = KW'(keep_q);

  always_comb begin
    if (keep_ext == '0) begin
      keep_eff = CW'(1);
    end else if (keep_ext > KW'(MAX_KEEP)) begin
      keep_eff = CW'(MAX_KEEP);
    end else begin
      keep_eff = CW'(keep_ext);
    end
  end

  assign count_eff = (count_q > keep_eff) ? keep_eff : count_q;

  for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
    logic [sks_pkg::VALUE_W-1:0] ins_val, shf_val;
    logic                        we;

    // empty cells count as larger than any value
    assign gt[g] = (CW'(g) >= count_eff) || (cell_q[g] > value_i);
    assign we    = (CW'(g) <= count_eff) && (CW'(g) < keep_eff);

    if (g == 0) begin : g_first
      assign ins_val = gt[g] ? value_i : cell_q[g];
    end else begin : g_rest
      assign ins_val = gt[g] ? (gt[g-1] ? cell_q[g-1] : value_i) : cell_q[g];
    end

    if (g == MAX_KEEP - 1) begin : g_top
      assign shf_val = cell_q[g];
    end else begin : g_mid
      assign shf_val = cell_q[g+1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.insert && we) begin
        cell_q[g] <= ins_val;
      end else if (cmd_i.shift) begin
        cell_q[g] <= shf_val;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = (count_eff < keep_eff) ? count_eff + CW'(1) : count_eff;
    end else if (cmd_i.shift) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      keep_q  <= sks_pkg::KEEP_RESET;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) keep_q <= cfg_wdata_i;
    end
  end

  assign stat_o.one_left = (count_q == CW'(1));
  assign head_o          = cell_q[0];

endmodule

/* bench/testbench.sv */
// self-checking testbench for the streaming k-smallest selector
module testbench;
  import sks_pkg::*;

  localparam int ITEM_TARGET = 410;
  localparam int IDLE_LIMIT  = 1000;
  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  class k_smallest_board;
    logic [VALUE_W-1:0] kept [MAX_KEEP_DEF];
    int held;
    logic [KEEP_W-1:0] keep_reg;
    sks_out_t expected_list[$];
    int errors;

    function new();
      held = 0;
      keep_reg = KEEP_RESET;
      errors = 0;
    endfunction

    function void set_keep(logic [KEEP_W-1:0] k);
      keep_reg = k;
    endfunction

    function int pending();
      return expected_list.size();
    endfunction

    function void note_sample(sks_in_t it);
      int k;
      int pos;
      int i;
      sks_out_t r;
      if (keep_reg == 0) k = 1;
      else if (int'(keep_reg) > MAX_KEEP_DEF) k = MAX_KEEP_DEF;
      else k = int'(keep_reg);
      if (held > k) held = k;
      pos = -1;
      if (held < k) begin
        pos = held;
        held++;
      end else if (it.value < kept[k-1]) begin
        pos = k - 1;
      end
      if (pos >= 0) begin
        while (pos > 0 && kept[pos-1] > it.value) begin
          kept[pos] = kept[pos-1];
          pos--;
        end
        kept[pos] = it.value;
      end
      if (it.last_item) begin
        for (i = 0; i < held; i++) begin
          r.smallest_value = kept[i];
          r.end_of_list = (i == held - 1);
          expected_list.push_back(r);
        end
        held = 0;
      end
    endfunction

    function void check_emitted(sks_out_t got);
      sks_out_t want;
      if (expected_list.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual value=%0h end_of_list=%0b",
                 $time, got.smallest_value, got.end_of_list);
        return;
      end
      want = expected_list.pop_front();
      if (got.smallest_value !== want.smallest_value) begin
        errors++;
        $display("%0t: smallest_value mismatch, expected %0h actual %0h",
                 $time, want.smallest_value, got.smallest_value);
      end
      if (got.end_of_list !== want.end_of_list) begin
        errors++;
        $display("%0t: end_of_list mismatch, expected %0b actual %0b",
                 $time, want.end_of_list, got.end_of_list);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  sks_in_t           item_i;
  logic              cfg_we_i;
  logic [KEEP_W-1:0] cfg_wdata_i;
  logic              result_valid_o;
  sks_out_t          result_o;

  k_smallest_board sb;
  int items_sent;
  int burst_left;
  int idle_cycles;

  stream_k_smallest_select_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // monitor: results first, they always belong to earlier transactions
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((result_valid_o && sb.pending() != 0) || (start && !busy)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (result_valid_o) begin
        sb.check_emitted(result_o);
      end
      if (start && !busy) begin
        sb.note_sample(item_i);
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic [VALUE_W-1:0] v, input logic lst);
    sks_in_t it;
    int gap;
    it.value = v;
    it.last_item = lst;
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_keep(input logic [KEEP_W-1:0] k);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= k;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_keep(k);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: pick_value = VALUE_W'($urandom_range(0, 20));
      3:       pick_value = ($urandom_range(0, 1) != 0) ? VALUE_MAX : '0;
      4:       pick_value = VALUE_MAX - VALUE_W'($urandom_range(0, 20));
      default: pick_value = VALUE_W'($urandom());
    endcase
  endfunction

  function automatic logic [KEEP_W-1:0] pick_keep();
    case ($urandom_range(0, 9))
      0:       pick_keep = 5'd0;
      1:       pick_keep = 5'd1;
      2:       pick_keep = 5'd2;
      3:       pick_keep = 5'd31;
      4:       pick_keep = 5'd16;
      5:       pick_keep = 5'd17;
      default: pick_keep = KEEP_W'($urandom_range(0, 31));
    endcase
  endfunction

  initial begin
    int len;
    int cut;
    int n;
    int sets;
    sb = new();
    items_sent = 0;
    burst_left = 0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // short set of one item at reset keep count
    send_sample(VALUE_MAX, 1'b1);
    // ties and extremes
    send_sample(30'd5, 1'b0);
    send_sample(30'd5, 1'b0);
    send_sample(30'd0, 1'b0);
    send_sample(VALUE_MAX, 1'b0);
    send_sample(30'd5, 1'b0);
    send_sample(30'd3, 1'b1);
    write_keep(5'd1);
    send_sample(30'd7, 1'b0);
    send_sample(30'd3, 1'b0);
    send_sample(30'd3, 1'b0);
    send_sample(30'd9, 1'b1);
    // zero acts as one
    write_keep(5'd0);
    send_sample(30'd4, 1'b0);
    send_sample(30'd2, 1'b1);
    // keep count lowered in the middle of a set
    write_keep(5'd4);
    send_sample(30'd10, 1'b0);
    send_sample(30'd20, 1'b0);
    send_sample(30'd30, 1'b0);
    send_sample(30'd40, 1'b0);
    send_sample(30'd50, 1'b0);
    write_keep(5'd2);
    send_sample(30'd25, 1'b0);
    send_sample(30'd5, 1'b1);
    write_keep(5'd31);

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 2) != 0) write_keep(pick_keep());
      sets = $urandom_range(1, 4);
      repeat (sets) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 18);
        cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, len) : 0;
        for (n = 1; n <= len; n++) begin
          if (n == cut) write_keep(pick_keep());
          send_sample(pick_value(), n == len);
        end
        if ($urandom_range(0, 7) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      if (sb.pending() != 0)
        $display("%0t: %0d expected results never arrived", $time, sb.pending());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/sks_pkg.sv
design/sks_ctrl.sv
design/sks_datapath.sv
design/stream_k_smallest_select_top.sv
bench/testbench.sv
